// ===== rtl/core/size_class_block_allocator_assert.svh =====
// assertion macros shared by the allocator modules
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while in reset
`define SCA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SCA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sca_pkg.sv =====
// types, codes and constants of the size class block allocator
package sca_pkg;

  localparam int DEF_POOLS    = 4;
  localparam int DEF_BLOCKS   = 16;
  localparam int CFG_POOLS    = 4;
  localparam int HANDLE_LIMIT = 16;

  localparam int SIZE_W    = 16;
  localparam int PSEL_W    = 2;
  localparam int BSEL_W    = 4;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } sca_cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_FREED        = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_BAD_HANDLE   = 3'd5
  } sca_status_e;

  // register map: block sizes first, then block counts
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BASE = 3'd4;

  localparam logic [SIZE_W-1:0] SIZE_RESET [CFG_POOLS] = '{
    16'd16, 16'd64, 16'd256, 16'd1024
  };

  typedef struct packed {
    sca_cmd_e              cmd;
    logic [SIZE_W-1:0]     req_size;
    logic [PSEL_W-1:0]     pool_sel;
    logic [BSEL_W-1:0]     block_sel;
  } sca_in_t;

  typedef struct packed {
    sca_status_e           status;
    logic [PSEL_W-1:0]     pool_out;
    logic [BSEL_W-1:0]     block_out;
    logic [CNT_W-1:0]      pool_used;
  } sca_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [SIZE_W-1:0]     value;
  } sca_cfg_t;

  // state update from the sequencer to the pool registers
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic                  cnt_wr;
    logic [PSEL_W-1:0]     pool;
    logic [BSEL_W-1:0]     blk;
    logic [CNT_W-1:0]      cnt;
  } sca_upd_t;

  // one pool as seen through the read port
  typedef struct packed {
    logic [SIZE_W-1:0]       size;
    logic [CNT_W-1:0]        eff;
    logic [HANDLE_LIMIT-1:0] map;
    logic [CNT_W-1:0]        used;
  } sca_pool_view_t;

  typedef struct packed {
    logic                  req;
    logic [PSEL_W-1:0]     pool;
  } sca_recount_t;

endpackage

// ===== rtl/core/sca_chan_if.sv =====
// valid/ready channel carrying one payload beat
interface sca_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sca_cmp.sv =====
// shared magnitude comparator, a less than b
module sca_cmp (
  input  logic [sca_pkg::SIZE_W-1:0] a_i,
  input  logic [sca_pkg::SIZE_W-1:0] b_i,
  output logic                       lt_o
);
  import sca_pkg::*;

  logic [SIZE_W:0] diff;

  // borrow out of the subtract
  assign diff = {1'b0, a_i} - {1'b0, b_i};
  assign lt_o = diff[SIZE_W];
endmodule

// ===== rtl/core/sca_pool_regs.sv =====
// pool configuration, used bitmaps and used counts
`include "size_class_block_allocator_assert.svh"
module sca_pool_regs #(
  parameter int POOLS           = sca_pkg::DEF_POOLS,
  parameter int BLOCKS_PER_POOL = sca_pkg::DEF_BLOCKS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_fire_i,
  input  sca_pkg::sca_cfg_t           cfg_i,
  input  sca_pkg::sca_upd_t           upd_i,
  input  logic [sca_pkg::PSEL_W-1:0]  rd_pool_i,
  output sca_pkg::sca_pool_view_t     rd_o,
  output sca_pkg::sca_recount_t       recount_o
);
  import sca_pkg::*;

  localparam int NP = (POOLS < CFG_POOLS) ? POOLS : CFG_POOLS;
  localparam int NB = (BLOCKS_PER_POOL < HANDLE_LIMIT) ? BLOCKS_PER_POOL : HANDLE_LIMIT;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;

  logic [SIZE_W-1:0] size_q  [NP];
  logic [CNT_W-1:0]  count_q [NP];
  logic [NB-1:0]     map_q   [NP];
  logic [CNT_W-1:0]  used_q  [NP];

  logic              cfg_count;
  logic              cfg_pool_ok;
  logic [PSEL_W-1:0] cfg_pool;
  logic [CNT_W-1:0]  cfg_eff;
  logic [NB-1:0]     cfg_mask;
  logic [PW-1:0]     cp;
  logic [PW-1:0]     up;
  logic [PW-1:0]     rp;
  logic [BW-1:0]     ub;

  // register decode, count saturates at the pool depth
  always_comb begin
    cfg_count = (cfg_i.index >= REG_COUNT_BASE);
    if (cfg_count) begin
      cfg_pool = PSEL_W'(cfg_i.index - REG_COUNT_BASE);
    end else begin
      cfg_pool = PSEL_W'(cfg_i.index - REG_SIZE_BASE);
    end
    cfg_pool_ok = (32'(cfg_pool) < NP);
    if (32'(cfg_i.value[CNT_W-1:0]) > NB) begin
      cfg_eff = CNT_W'(NB);
    end else begin
      cfg_eff = cfg_i.value[CNT_W-1:0];
    end
    for (int b = 0; b < NB; b++) begin
      cfg_mask[b] = (32'(cfg_eff) > b);
    end
  end

  assign cp = cfg_pool[PW-1:0];
  assign up = upd_i.pool[PW-1:0];
  assign ub = upd_i.blk[BW-1:0];

  assign recount_o.req  = cfg_fire_i && cfg_count && cfg_pool_ok;
  assign recount_o.pool = cfg_pool;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) begin
        size_q[p]  <= SIZE_RESET[p];
        count_q[p] <= '0;
        map_q[p]   <= '0;
        used_q[p]  <= '0;
      end
    end else begin
      if (cfg_fire_i && cfg_pool_ok) begin
        if (cfg_count) begin
          count_q[cp] <= cfg_eff;
          map_q[cp]   <= map_q[cp] & cfg_mask;
        end else begin
          size_q[cp] <= cfg_i.value;
        end
      end
      if (upd_i.set) begin
        map_q[up][ub] <= 1'b1;
        used_q[up]    <= used_q[up] + 1'b1;
      end
      if (upd_i.clr) begin
        map_q[up][ub] <= 1'b0;
        if (used_q[up] != '0) begin
          used_q[up] <= used_q[up] - 1'b1;
        end
      end
      if (upd_i.cnt_wr) begin
        used_q[up] <= upd_i.cnt;
      end
    end
  end

  // single read port, pools that do not exist read as zero
  always_comb begin
    rp   = rd_pool_i[PW-1:0];
    rd_o = '0;
    if (32'(rd_pool_i) < NP) begin
      rd_o.size = size_q[rp];
      rd_o.eff  = count_q[rp];
      rd_o.map  = HANDLE_LIMIT'(map_q[rp]);
      rd_o.used = used_q[rp];
    end
  end

  `SCA_ASSERT_IMP(a_set_free, clk_i, rst_ni, upd_i.set, !map_q[up][ub], "grant of a used block")
  `SCA_ASSERT_IMP(a_clr_used, clk_i, rst_ni, upd_i.clr, map_q[up][ub], "free of an unused block")
  `SCA_ASSERT_IMP(a_set_room, clk_i, rst_ni, upd_i.set, used_q[up] < count_q[up], "pool overfilled")
endmodule

// ===== rtl/core/sca_seq.sv =====
// command sequencer driving the shared comparator
`include "size_class_block_allocator_assert.svh"
module sca_seq #(
  parameter int POOLS           = sca_pkg::DEF_POOLS,
  parameter int BLOCKS_PER_POOL = sca_pkg::DEF_BLOCKS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sca_pkg::sca_in_t            in_data_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  sca_pkg::sca_recount_t       recount_i,
  input  sca_pkg::sca_pool_view_t     rd_i,
  output logic [sca_pkg::PSEL_W-1:0]  rd_pool_o,
  output sca_pkg::sca_upd_t           upd_o,
  output logic [sca_pkg::SIZE_W-1:0]  cmp_a_o,
  output logic [sca_pkg::SIZE_W-1:0]  cmp_b_o,
  input  logic                        cmp_lt_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sca_pkg::sca_out_t           out_data_o
);
  import sca_pkg::*;

  localparam int NP = (POOLS < CFG_POOLS) ? POOLS : CFG_POOLS;
  localparam int NB = (BLOCKS_PER_POOL < HANDLE_LIMIT) ? BLOCKS_PER_POOL : HANDLE_LIMIT;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FIT     = 7'b0000010,
    S_BEST    = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_FREE    = 7'b0010000,
    S_RECOUNT = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_e;

  function automatic sca_out_t mk_res(sca_status_e st, logic [PSEL_W-1:0] p,
                                      logic [BSEL_W-1:0] b, logic [CNT_W-1:0] u);
    sca_out_t r;
    r.status    = st;
    r.pool_out  = p;
    r.block_out = b;
    r.pool_used = u;
    return r;
  endfunction

  state_e            state_q, state_d;
  sca_in_t           req_q, req_d;
  logic [PSEL_W-1:0] pidx_q, pidx_d;
  logic              found_q, found_d;
  logic [PSEL_W-1:0] best_q, best_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d;
  logic [CNT_W-1:0]  bidx_q, bidx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PSEL_W-1:0] rc_pool_q, rc_pool_d;
  sca_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  sca_out_t          out_q, out_d;

  logic              in_fire;
  logic              take;
  logic              last_pool;

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pidx_d      = pidx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_size_d = best_size_q;
    bidx_d      = bidx_q;
    cnt_d       = cnt_q;
    rc_pool_d   = rc_pool_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    upd_o       = '0;
    rd_pool_o   = pidx_q;
    cmp_a_o     = rd_i.size;
    cmp_b_o     = req_q.req_size;
    take        = 1'b0;
    last_pool   = (32'(pidx_q) == NP - 1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (recount_i.req) begin
          rc_pool_d = recount_i.pool;
          bidx_d    = '0;
          cnt_d     = '0;
          state_d   = S_RECOUNT;
        end else if (in_fire) begin
          req_d = in_data_i;
          if (in_data_i.cmd == CMD_ALLOC) begin
            pidx_d  = '0;
            found_d = 1'b0;
            state_d = S_FIT;
          end else begin
            state_d = S_FREE;
          end
        end
      end

      // does pool pidx hold the request
      S_FIT: begin
        rd_pool_o = pidx_q;
        cmp_a_o   = rd_i.size;
        cmp_b_o   = req_q.req_size;
        take      = (rd_i.eff != '0) && !cmp_lt_i;
        if (take && found_q) begin
          state_d = S_BEST;
        end else begin
          if (take) begin
            best_d      = pidx_q;
            best_size_d = rd_i.size;
            found_d     = 1'b1;
          end
          if (last_pool) begin
            if (take || found_q) begin
              bidx_d  = '0;
              state_d = S_SCAN;
            end else begin
              res_d   = mk_res(ST_TOO_LARGE, '0, '0, '0);
              state_d = S_EMIT;
            end
          end else begin
            pidx_d = pidx_q + 1'b1;
          end
        end
      end

      // strictly smaller wins, so ties keep the lower pool
      S_BEST: begin
        rd_pool_o = pidx_q;
        cmp_a_o   = rd_i.size;
        cmp_b_o   = best_size_q;
        if (cmp_lt_i) begin
          best_d      = pidx_q;
          best_size_d = rd_i.size;
        end
        if (last_pool) begin
          bidx_d  = '0;
          state_d = S_SCAN;
        end else begin
          pidx_d  = pidx_q + 1'b1;
          state_d = S_FIT;
        end
      end

      // lowest free block of the chosen pool
      S_SCAN: begin
        rd_pool_o = best_q;
        cmp_a_o   = SIZE_W'(bidx_q);
        cmp_b_o   = SIZE_W'(rd_i.eff);
        if (!cmp_lt_i) begin
          res_d   = mk_res(ST_EXHAUSTED, best_q, '0, rd_i.used);
          state_d = S_EMIT;
        end else if (!rd_i.map[bidx_q[BSEL_W-1:0]]) begin
          upd_o.set  = 1'b1;
          upd_o.pool = best_q;
          upd_o.blk  = bidx_q[BSEL_W-1:0];
          res_d      = mk_res(ST_GRANTED, best_q, bidx_q[BSEL_W-1:0], rd_i.used + 1'b1);
          state_d    = S_EMIT;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end

      S_FREE: begin
        rd_pool_o = req_q.pool_sel;
        cmp_a_o   = SIZE_W'(req_q.block_sel);
        cmp_b_o   = SIZE_W'(rd_i.eff);
        if (32'(req_q.pool_sel) >= NP) begin
          res_d = mk_res(ST_BAD_HANDLE, req_q.pool_sel, '0, '0);
        end else if (!cmp_lt_i) begin
          res_d = mk_res(ST_BAD_HANDLE, req_q.pool_sel, '0, rd_i.used);
        end else if (!rd_i.map[req_q.block_sel]) begin
          res_d = mk_res(ST_ALREADY_FREE, req_q.pool_sel, '0, rd_i.used);
        end else begin
          upd_o.clr  = 1'b1;
          upd_o.pool = req_q.pool_sel;
          upd_o.blk  = req_q.block_sel;
          if (rd_i.used != '0) begin
            res_d = mk_res(ST_FREED, req_q.pool_sel, req_q.block_sel, rd_i.used - 1'b1);
          end else begin
            res_d = mk_res(ST_FREED, req_q.pool_sel, req_q.block_sel, '0);
          end
        end
        state_d = S_EMIT;
      end

      // bit by bit popcount after a block count write
      S_RECOUNT: begin
        rd_pool_o = rc_pool_q;
        cmp_a_o   = SIZE_W'(bidx_q);
        cmp_b_o   = SIZE_W'(NB);
        if (cmp_lt_i) begin
          cnt_d  = cnt_q + CNT_W'(rd_i.map[bidx_q[BSEL_W-1:0]]);
          bidx_d = bidx_q + 1'b1;
        end else begin
          upd_o.cnt_wr = 1'b1;
          upd_o.pool   = rc_pool_q;
          upd_o.cnt    = cnt_q;
          state_d      = S_IDLE;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      bidx_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pidx_q      <= pidx_d;
      found_q     <= found_d;
      bidx_q      <= bidx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    best_q      <= best_d;
    best_size_q <= best_size_d;
    rc_pool_q   <= rc_pool_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  `SCA_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_fire, !in_ready_o, "item taken while busy")
  `SCA_ASSERT_IMP(a_scan_pool, clk_i, rst_ni, state_q == S_SCAN, found_q, "scan with no pool")
  `SCA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q, "result beat dropped")
endmodule

// ===== rtl/core/size_class_block_allocator.sv =====
// top level of the size class block allocator
//
// usage:
// - cfg_i takes register writes (index, value): indexes 0..3 set the block
//   size of pools 0..3, indexes 4..7 set their block counts (0 = no pool)
// - in_i takes one command beat: allocate (req_size) or free (pool_sel,
//   block_sel); out_o returns exactly one result beat per command
// - allocate walks the pools through one shared comparator, one pass per
//   pool plus a second for each fitting pool after the first, then, if a
//   pool fits, walks the used bits of the chosen pool one block per cycle
// - free steps through accept, handle check and result load
// - the result passes through the result stage and waits in the output
//   register; a stalled receiver holds the block in its result stage
//   until that register empties, input stays not ready meanwhile
// - a block count write drops the used marks beyond the new count and then
//   recounts the pool with both channels not ready
// - reset frees every block, zeroes the counts and loads the default sizes;
//   no clearing pass is needed
module size_class_block_allocator #(
  parameter int POOLS           = sca_pkg::DEF_POOLS,
  parameter int BLOCKS_PER_POOL = sca_pkg::DEF_BLOCKS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sca_chan_if.sink   cfg_i,
  sca_chan_if.sink   in_i,
  sca_chan_if.source out_o
);
  import sca_pkg::*;

  // pool state read port and update path
  sca_pool_view_t    rd_view;
  logic [PSEL_W-1:0] rd_pool;
  sca_upd_t          upd;
  sca_recount_t      recount;

  // shared comparator operands
  logic [SIZE_W-1:0] cmp_a;
  logic [SIZE_W-1:0] cmp_b;
  logic              cmp_lt;

  logic              cfg_ready;
  logic              in_ready;
  logic              cfg_fire;

  assign cfg_i.ready = cfg_ready;
  assign in_i.ready  = in_ready;
  assign cfg_fire    = cfg_i.valid && cfg_ready;

  sca_pool_regs #(
    .POOLS           (POOLS),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_fire_i (cfg_fire),
    .cfg_i      (cfg_i.data),
    .upd_i      (upd),
    .rd_pool_i  (rd_pool),
    .rd_o       (rd_view),
    .recount_o  (recount)
  );

  // one comparator serves size fit, best size, block range and recount
  sca_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  sca_seq #(
    .POOLS           (POOLS),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_ready),
    .recount_i   (recount),
    .rd_i        (rd_view),
    .rd_pool_o   (rd_pool),
    .upd_o       (upd),
    .cmp_a_o     (cmp_a),
    .cmp_b_o     (cmp_b),
    .cmp_lt_i    (cmp_lt),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );
endmodule

// ===== sim/size_class_block_allocator_tb.sv =====
// self-checking testbench of the size class block allocator
module size_class_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sca_pkg::*;

  localparam int POOL_N      = DEF_POOLS;
  localparam int BLOCK_N     = DEF_BLOCKS;
  // a block count saturates at the smaller of pool depth and handle range
  localparam int EFF_MAX     = (BLOCK_N < HANDLE_LIMIT) ? BLOCK_N : HANDLE_LIMIT;
  localparam int IDLE_PCT    = 34;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 228;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  // mirror of the pool registers and used marks, plus the results still owed
  class alloc_scoreboard;
    logic [SIZE_W-1:0]       blk_size  [POOL_N];
    logic [CNT_W-1:0]        blk_count [POOL_N];
    logic [HANDLE_LIMIT-1:0] used_map  [POOL_N];
    logic [CNT_W-1:0]        used_cnt  [POOL_N];
    sca_out_t                owed_q [$];
    int                      errors;

    function new();
      for (int p = 0; p < POOL_N; p++) begin
        blk_size[p]  = SIZE_RESET[p];
        blk_count[p] = '0;
        used_map[p]  = '0;
        used_cnt[p]  = '0;
      end
      errors = 0;
    endfunction

    function int eff(int p);
      return (blk_count[p] > EFF_MAX) ? EFF_MAX : int'(blk_count[p]);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      int p;
      if (idx < REG_COUNT_BASE) begin
        blk_size[idx - REG_SIZE_BASE] = val;
      end else begin
        p = int'(idx - REG_COUNT_BASE);
        blk_count[p] = val[CNT_W-1:0];
        // marks at or beyond the new count are dropped
        for (int b = eff(p); b < HANDLE_LIMIT; b++) used_map[p][b] = 1'b0;
        used_cnt[p] = CNT_W'($countones(used_map[p]));
      end
    endfunction

    function void note_command(sca_in_t c);
      sca_out_t r;
      int       best;
      bit       found;
      bit       granted;
      int       ps;
      r = '0;
      found = 1'b0;
      granted = 1'b0;
      best = 0;
      ps = int'(c.pool_sel);
      if (c.cmd == CMD_ALLOC) begin
        // smallest fitting pool among present ones, lower index on a tie
        for (int p = 0; p < POOL_N; p++) begin
          if (eff(p) != 0 && blk_size[p] >= c.req_size) begin
            if (!found || blk_size[p] < blk_size[best]) begin
              best = p;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.pool_out = PSEL_W'(best);
          for (int b = 0; b < eff(best) && !granted; b++) begin
            if (!used_map[best][b]) begin
              used_map[best][b] = 1'b1;
              used_cnt[best]++;
              r.block_out = BSEL_W'(b);
              granted = 1'b1;
            end
          end
          r.status    = granted ? ST_GRANTED : ST_EXHAUSTED;
          r.pool_used = used_cnt[best];
        end
      end else begin
        r.pool_out  = c.pool_sel;
        r.pool_used = used_cnt[ps];
        if (c.block_sel >= eff(ps)) begin
          r.status = ST_BAD_HANDLE;
        end else if (!used_map[ps][c.block_sel]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          used_map[ps][c.block_sel] = 1'b0;
          if (used_cnt[ps] > 0) used_cnt[ps]--;
          r.status    = ST_FREED;
          r.block_out = c.block_sel;
          r.pool_used = used_cnt[ps];
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(sca_out_t got);
      sca_out_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d", int'(got.status));
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", int'(want.status), int'(got.status));
        errors++;
      end
      if (got.pool_out !== want.pool_out) begin
        $error("pool_out: expected %0d, got %0d", want.pool_out, got.pool_out);
        errors++;
      end
      if (got.block_out !== want.block_out) begin
        $error("block_out: expected %0d, got %0d", want.block_out, got.block_out);
        errors++;
      end
      if (got.pool_used !== want.pool_used) begin
        $error("pool_used: expected %0d, got %0d", want.pool_used, got.pool_used);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // some block currently marked used, for well-formed frees
    function bit pick_used(output logic [PSEL_W-1:0] p, output logic [BSEL_W-1:0] b);
      logic [PSEL_W+BSEL_W-1:0] handles [$];
      for (int i = 0; i < POOL_N; i++) begin
        for (int j = 0; j < HANDLE_LIMIT; j++) begin
          if (used_map[i][j]) handles.push_back({PSEL_W'(i), BSEL_W'(j)});
        end
      end
      if (handles.size() == 0) return 1'b0;
      {p, b} = handles[$urandom_range(handles.size() - 1)];
      return 1'b1;
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   gaps_on  = 1'b1;   // random idling on both sides
  bit   hold_req = 1'b0;   // asks the result sink for one long hold-off

  alloc_scoreboard sb = new();

  sca_chan_if #(.payload_t(sca_cfg_t)) cfg_ch ();
  sca_chan_if #(.payload_t(sca_in_t))  cmd_ch ();
  sca_chan_if #(.payload_t(sca_out_t)) res_ch ();

  size_class_block_allocator #(
    .POOLS          (POOL_N),
    .BLOCKS_PER_POOL(BLOCK_N)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (cmd_ch),
    .out_o (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // command beats: drive at the falling edge, count acceptance at the rising edge
  // valid is left high after a beat so back-to-back beats never drop it
  task automatic send_cmd(sca_in_t c);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(c);
  endtask

  // register write beats, same discipline as the command channel
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      cfg_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_idle();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering commands and let every owed result drain
  task automatic settle();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic sca_in_t alloc_item(logic [SIZE_W-1:0] req,
                                         logic [PSEL_W-1:0] ps = '0,
                                         logic [BSEL_W-1:0] bs = '0);
    sca_in_t c;
    c.cmd       = CMD_ALLOC;
    c.req_size  = req;
    c.pool_sel  = ps;
    c.block_sel = bs;
    return c;
  endfunction

  function automatic sca_in_t free_item(logic [PSEL_W-1:0] ps, logic [BSEL_W-1:0] bs,
                                        logic [SIZE_W-1:0] req = '0);
    sca_in_t c;
    c.cmd       = CMD_FREE;
    c.req_size  = req;
    c.pool_sel  = ps;
    c.block_sel = bs;
    return c;
  endfunction

  // requested sizes cluster around the configured block sizes
  function automatic logic [SIZE_W-1:0] pick_req();
    logic [SIZE_W-1:0] s;
    s = sb.blk_size[$urandom_range(POOL_N - 1)];
    case ($urandom_range(5))
      0:       return s;
      1:       return s + 1'b1;
      2:       return s - 1'b1;
      3:       return SIZE_W'($urandom_range(64));
      4:       return $urandom_range(1) ? '1 : '0;
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(1, 32));
      3:       return SIZE_W'($urandom_range(1, 300));
      4:       return SIZE_W'($urandom_range(256, 2048));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // counts above the pool depth and junk in the upper value bits too
  function automatic logic [SIZE_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SIZE_W'(EFF_MAX);
      2:       return SIZE_W'(31);
      3:       return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, EFF_MAX));
    endcase
  endfunction

  // mostly allocs and frees of live handles, the rest random handles
  function automatic sca_in_t pick_cmd();
    sca_in_t           c;
    logic [PSEL_W-1:0] p;
    logic [BSEL_W-1:0] b;
    int                roll;
    c.cmd       = CMD_ALLOC;
    c.req_size  = SIZE_W'($urandom);
    c.pool_sel  = PSEL_W'($urandom);
    c.block_sel = BSEL_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 50) begin
      c.cmd      = CMD_ALLOC;
      c.req_size = pick_req();
    end else begin
      c.cmd = CMD_FREE;
      if (roll < 85 && sb.pick_used(p, b)) begin
        c.pool_sel  = p;
        c.block_sel = b;
      end
    end
    return c;
  endfunction

  // new pool layout between phases; phases 5 and 6 pin the extremes
  task automatic configure_pools(int ph);
    for (int p = 0; p < POOL_N; p++) begin
      if (ph == 5) begin
        // every pool full size and equally large: ties everywhere
        cfg_write(REG_SIZE_BASE + CFG_IDX_W'(p), '1);
        cfg_write(REG_COUNT_BASE + CFG_IDX_W'(p), SIZE_W'(EFF_MAX));
      end else if (ph == 6) begin
        // one zero-byte block per pool
        cfg_write(REG_SIZE_BASE + CFG_IDX_W'(p), '0);
        cfg_write(REG_COUNT_BASE + CFG_IDX_W'(p), SIZE_W'(1));
      end else begin
        if ($urandom_range(3) != 0) cfg_write(REG_SIZE_BASE + CFG_IDX_W'(p), pick_size());
        if ($urandom_range(3) != 0) cfg_write(REG_COUNT_BASE + CFG_IDX_W'(p), pick_count());
      end
    end
    cfg_idle();
  endtask

  // result sink: random stalls, or one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // watchdog: too many cycles without a beat on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (res_ch.valid && res_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("size_class_block_allocator regression: fail");
    $finish;
  end

  initial begin : stimulus
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // out of reset no pool has blocks
    send_cmd(alloc_item('0));
    send_cmd(free_item(2, 0));
    settle();

    // zero-byte pool, a size tie between pools 1 and 2, a single max-size block
    cfg_write(REG_SIZE_BASE + CFG_IDX_W'(0), '0);
    cfg_write(REG_SIZE_BASE + CFG_IDX_W'(1), 16'd64);
    cfg_write(REG_SIZE_BASE + CFG_IDX_W'(2), 16'd64);
    cfg_write(REG_SIZE_BASE + CFG_IDX_W'(3), '1);
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(0), 16'd2);
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(1), SIZE_W'(EFF_MAX));
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(2), 16'd3);
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(3), 16'd1);
    cfg_idle();
    send_cmd(alloc_item('0));
    send_cmd(alloc_item('0, '1, '1));       // handle fields ignored on allocate
    send_cmd(alloc_item('0));               // chosen pool full
    send_cmd(alloc_item(16'd1));            // tie goes to the lower pool
    send_cmd(alloc_item(16'd64));
    send_cmd(alloc_item(16'd65));
    send_cmd(alloc_item('1));               // max request, pool full
    send_cmd(free_item(3, 0, '1));          // size field ignored on free
    send_cmd(free_item(3, 0));              // double free
    send_cmd(free_item(3, 1));              // block beyond the count
    send_cmd(free_item(0, 1));
    send_cmd(alloc_item('0));
    settle();

    // shrinking a pool drops the marks above the new count
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(1), 16'd1);
    cfg_idle();
    send_cmd(free_item(1, 1));
    send_cmd(free_item(1, 0));
    settle();

    // oversized count saturates, upper value bits fall away
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(3), 16'd31);
    cfg_write(REG_COUNT_BASE + CFG_IDX_W'(1), 16'hFFE0);
    cfg_idle();
    send_cmd(alloc_item(16'd1));
    send_cmd(free_item(1, 0));
    send_cmd(alloc_item('1));
    send_cmd(free_item(3, 15));

    // random phases; phase 1 runs without any idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      gaps_on = (ph != 1);
      configure_pools(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) hold_req = 1'b1;
        send_cmd(pick_cmd());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("size_class_block_allocator regression: pass");
    end else begin
      $display("size_class_block_allocator regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sca_pkg.sv
rtl/core/sca_chan_if.sv
rtl/core/sca_cmp.sv
rtl/core/sca_pool_regs.sv
rtl/core/sca_seq.sv
rtl/core/size_class_block_allocator.sv
sim/size_class_block_allocator_tb.sv
